// ----- hdl/wimr_pkg.sv -----
// shared constants and types for the wide integer modular reduction block
package wimr_pkg;

   localparam int NUM_WORDS  = 32;
   localparam int WORD_BITS  = 64;
   localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
   localparam int EMIT_WORDS = (NUM_WORDS < 32) ? NUM_WORDS : 32;
   localparam int IDX_W      = 5;
   localparam int POS_W      = (TOTAL_BITS > 1) ? $clog2(TOTAL_BITS) : 1;

   // control shared by every cell of the chain
   typedef struct packed {
      logic wr_div;     // write targets the dividend word
      logic wr_mod;     // write targets the modulus word
      logic load;       // copy dividend into quotient shifter, clear remainder
      logic commit;     // end of one bit step: take shifted or reduced value
      logic sub;        // reduced value wins at commit
      logic shift_out;  // move remainder one word toward cell zero
   } cell_ctl_type;

endpackage

// ----- hdl/wimr_if.sv -----
// valid/ready channels for input and result items
interface wimr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        target;
   logic [wimr_pkg::IDX_W-1:0]  word_index;
   logic [63:0]                 word_value;
   logic                        start_req;

   modport source (output valid, target, word_index, word_value, start_req, input ready);
   modport sink   (input valid, target, word_index, word_value, start_req, output ready);
endinterface

interface wimr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wimr_pkg::IDX_W-1:0]  result_index;
   logic [63:0]                 result_word;
   logic                        last_word;

   modport source (output valid, result_index, result_word, last_word, input ready);
   modport sink   (input valid, result_index, result_word, last_word, output ready);
endinterface

// ----- hdl/wide_integer_modular_reduction.sv -----
// top level: unsigned wide remainder built from a chain of word cells
// Each input item writes one 64-bit word of the dividend or the modulus; an item with
// start_req set is followed by the reduction and then 32 result items, least significant
// word first, last_word on the final one. No new item is taken until the final word has
// been delivered. The reduction is restoring shift-and-subtract, one quotient bit per
// step: a step sends a borrow token through the 32 cells, one cell per cycle, and then
// commits, and a reduction runs 2048 steps. A zero modulus returns the dividend.
module wide_integer_modular_reduction (
   input  logic             clock,
   input  logic             reset,
   wimr_req_if.sink         req_chan,
   wimr_rsp_if.source       rsp_chan
);

   localparam int N = wimr_pkg::NUM_WORDS;
   localparam int W = wimr_pkg::WORD_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SWEEP, ST_EMIT} state_type;

   state_type                     state_ff, state_in;
   logic [wimr_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [wimr_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          kick_ff, kick_in;
   wimr_pkg::cell_ctl_type        ctl;
   logic                          req_acc, rsp_acc, done;

   logic [N-1:0][W-1:0]           r_vec;
   logic [N-1:0]                  q_vec, b_vec, t_vec, wr_sel;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign done    = t_vec[N-1];

   // shared cell control
   always_comb begin
      ctl.wr_div    = req_acc && !req_chan.target;
      ctl.wr_mod    = req_acc &&  req_chan.target;
      ctl.load      = (state_ff == ST_LOAD);
      ctl.commit    = (state_ff == ST_SWEEP) && done;
      ctl.sub       = r_vec[N-1][W-1] || !b_vec[N-1];
      ctl.shift_out = rsp_acc;
   end

   // chain of cells
   for (genvar k = 0; k < N; k++) begin : g_cell
      logic            sb, qb, bi, ti;
      logic [W-1:0]    rh;
      if (k == 0) begin : g_lo
         assign sb = q_vec[N-1];
         assign qb = 1'b0;
         assign bi = 1'b0;
         assign ti = kick_ff;
      end else begin : g_mid
         assign sb = r_vec[k-1][W-1];
         assign qb = q_vec[k-1];
         assign bi = b_vec[k-1];
         assign ti = t_vec[k-1];
      end
      if (k == N - 1) begin : g_top
         assign rh = '0;
      end else begin : g_below
         assign rh = r_vec[k+1];
      end
      assign wr_sel[k] = (k < 32) && (32'(req_chan.word_index) == k);

      wimr_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .wr_sel       (wr_sel[k]),
         .wr_data      (req_chan.word_value),
         .shift_bit_in (sb),
         .q_bit_in     (qb),
         .borrow_in    (bi),
         .tok_in       (ti),
         .r_hi_in      (rh),
         .r_out        (r_vec[k]),
         .q_msb        (q_vec[k]),
         .borrow_out   (b_vec[k]),
         .tok_out      (t_vec[k])
      );
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      kick_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_chan.start_req) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            pos_in   = wimr_pkg::POS_W'(wimr_pkg::TOTAL_BITS - 1);
            kick_in  = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (done) begin
               if (pos_ff == '0) begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  pos_in  = pos_ff - 1'b1;
                  kick_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (idx_ff == wimr_pkg::IDX_W'(wimr_pkg::EMIT_WORDS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         idx_ff   <= '0;
         kick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
         kick_ff  <= kick_in;
      end
   end

   // handshake and result payload
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_EMIT);
   assign rsp_chan.result_index = idx_ff;
   assign rsp_chan.result_word  = r_vec[0];
   assign rsp_chan.last_word    = (idx_ff == wimr_pkg::IDX_W'(wimr_pkg::EMIT_WORDS - 1));

   // checks
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(t_vec))
      else $error("more than one cell holds the step token");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input taken while results pending");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.start_req |=> !req_chan.ready)
      else $error("start item did not launch a reduction");
   a_commit_sweep: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == ST_SWEEP))
      else $error("token left the chain outside a sweep");

endmodule

// ----- hdl/wimr_cell.sv -----
// one 64-bit slice of the reduction chain: operand words, remainder and quotient shifter
module wimr_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  wimr_pkg::cell_ctl_type              ctl,
   input  logic                                wr_sel,
   input  logic [wimr_pkg::WORD_BITS-1:0]      wr_data,
   input  logic                                shift_bit_in,
   input  logic                                q_bit_in,
   input  logic                                borrow_in,
   input  logic                                tok_in,
   input  logic [wimr_pkg::WORD_BITS-1:0]      r_hi_in,
   output logic [wimr_pkg::WORD_BITS-1:0]      r_out,
   output logic                                q_msb,
   output logic                                borrow_out,
   output logic                                tok_out
);

   logic [wimr_pkg::WORD_BITS-1:0] div_ff, mod_ff, r_ff, q_ff, d_ff;
   logic                           borrow_ff, tok_ff;
   logic [wimr_pkg::WORD_BITS-1:0] shifted;
   logic [wimr_pkg::WORD_BITS:0]   diff;

   // remainder shifted up one bit, and its difference against the modulus word
   assign shifted = {r_ff[wimr_pkg::WORD_BITS-2:0], shift_bit_in};
   assign diff    = {1'b0, shifted} - {1'b0, mod_ff} - {{wimr_pkg::WORD_BITS{1'b0}}, borrow_in};

   // operand stores and step token
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
         mod_ff <= '0;
         tok_ff <= 1'b0;
      end else begin
         if (wr_sel && ctl.wr_div) begin
            div_ff <= wr_data;
         end
         if (wr_sel && ctl.wr_mod) begin
            mod_ff <= wr_data;
         end
         tok_ff <= tok_in;
      end
   end

   // word difference and remainder / quotient update
   always_ff @(posedge clock) begin
      if (tok_in) begin
         d_ff      <= diff[wimr_pkg::WORD_BITS-1:0];
         borrow_ff <= diff[wimr_pkg::WORD_BITS];
      end
      if (ctl.load) begin
         q_ff <= div_ff;
         r_ff <= '0;
      end else if (ctl.commit) begin
         r_ff <= ctl.sub ? d_ff : shifted;
         q_ff <= {q_ff[wimr_pkg::WORD_BITS-2:0], q_bit_in};
      end else if (ctl.shift_out) begin
         r_ff <= r_hi_in;
      end
   end

   assign r_out      = r_ff;
   assign q_msb      = q_ff[wimr_pkg::WORD_BITS-1];
   assign borrow_out = borrow_ff;
   assign tok_out    = tok_ff;

endmodule
